// ----- hdl/datetime_difference_defines.svh -----
// assertion macros for the date-time difference block
// used by the checker; relies on clk and rst in the including scope
`ifndef DATETIME_DIFFERENCE_DEFINES_SVH
`define DATETIME_DIFFERENCE_DEFINES_SVH

// same-cycle implication, off during reset
`define DTD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dtdiff_pkg.sv -----
// shared widths, field layout, types and calendar tables for the date-time difference block
// no dependencies; used by datetime_difference and dtdiff_checker
package dtdiff_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DT_W    = DAY_W + MON_W + YEAR_W + HOUR_W + MIN_W + SEC_W;
  localparam int IN_W    = 2 * DT_W;

  localparam int DAYS_W  = 22;
  localparam int DAYS_LSB = 0;
  localparam int HRS_LSB  = DAYS_LSB + DAYS_W;
  localparam int MINS_LSB = HRS_LSB + HOUR_W;
  localparam int SECS_LSB = MINS_LSB + MIN_W;
  localparam int RES_W    = SECS_LSB + SEC_W;
  localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

  // internal widths
  localparam int DAYNUM_W    = 23;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + 13;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int LEAP_W      = YEAR_W - 1;
  localparam int DBM_W       = 9;
  localparam int OFF_W       = 10;

  // calendar constants
  localparam logic [YEAR_W-1:0] YEAR_MAX      = YEAR_W'(9999);
  localparam logic [HOUR_W-1:0] HOUR_MAX      = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX       = MIN_W'(59);
  localparam logic [SEC_W-1:0]  SEC_MAX       = SEC_W'(59);
  localparam logic [MON_W-1:0]  MON_FIRST     = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_LAST      = MON_W'(12);
  localparam logic [MON_W-1:0]  MON_FEB       = MON_W'(2);
  localparam logic [HOUR_W-1:0] HOURS_PER_DAY = HOUR_W'(24);
  localparam logic [MIN_W-1:0]  MINS_PER_HOUR = MIN_W'(60);
  localparam logic [SEC_W-1:0]  SECS_PER_MIN  = SEC_W'(60);
  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  // ceil(2^19 / 100), exact floor(y / 100) for any 14-bit y
  localparam int RECIP_100     = 5243;

  // one date-time as packed in tdata, day in the lowest bits
  typedef struct packed {
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } dt_fields_t;

  // time of day, hour on top so the packed value orders correctly
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                 len = DAY_W'(31);
    endcase
    return len;
  endfunction

  function automatic logic [DBM_W-1:0] days_before(input logic [MON_W-1:0] month);
    logic [DBM_W-1:0] d;
    unique case (month)
      4'd2:    d = DBM_W'(31);
      4'd3:    d = DBM_W'(59);
      4'd4:    d = DBM_W'(90);
      4'd5:    d = DBM_W'(120);
      4'd6:    d = DBM_W'(151);
      4'd7:    d = DBM_W'(181);
      4'd8:    d = DBM_W'(212);
      4'd9:    d = DBM_W'(243);
      4'd10:   d = DBM_W'(273);
      4'd11:   d = DBM_W'(304);
      4'd12:   d = DBM_W'(334);
      default: d = DBM_W'(0);
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/datetime_difference.sv -----
// top level: absolute difference of two gregorian date-times, five-stage pipeline
// depends on dtdiff_pkg
//
//  channel  | dir | signals                          | carries
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | tvalid, tready, tdata[79:0]      | two date-times, one pair per transfer
//  m_axis   | out | tvalid, tready, tdata[39:0], tuser | day/h/m/s difference, valid flag
//
// one pair enters per cycle unless a stall at m_axis_tready backs up into a full pipeline;
// each of the five register stages holds one item
// stage 1 does the year*reciprocal multiply, stage 2 the century split and y*365,
// stage 3 the day-number add, stage 4 the ordering compare, stage 5 the borrow subtract
// each stage loads when it is empty or its successor loads, so bubbles close up under stall
// rst (synchronous) clears only the stage valid bits; payload registers are not reset
module datetime_difference (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_day, first_month, first_year, first_hour, first_minute, first_second,
  // second_day, second_month, second_year, second_hour, second_minute, second_sec
  input  logic [dtdiff_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // diff_days, diff_hours, diff_minutes, diff_seconds, one zero pad bit
  output logic [dtdiff_pkg::OUT_W-1:0] m_axis_tdata,
  // valid_res
  output logic                       m_axis_tuser
);
  import dtdiff_pkg::*;

  // stage valid bits and load enables
  logic vld1, vld2, vld3, vld4, vld5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !vld5 || m_axis_tready;
  assign en4 = !vld4 || en5;
  assign en3 = !vld3 || en4;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = vld5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (en1) vld1 <= s_axis_tvalid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en4) vld4 <= vld3;
      if (en5) vld5 <= vld4;
    end
  end

  // per-date lanes, stages 1 to 3
  dt_fields_t           fld1   [2];
  logic                 ok1    [2];
  logic [PROD_W-1:0]    prod1  [2];

  logic [DAYNUM_W-1:0]  y365_2 [2];
  logic [LEAP_W-1:0]    leaps2 [2];
  logic [OFF_W-1:0]     off2   [2];
  logic                 ok2    [2];
  tod_t                 tod2   [2];

  logic [DAYNUM_W-1:0]  dnum3  [2];
  logic                 ok3    [2];
  tod_t                 tod3   [2];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    dt_fields_t         fin;
    logic               ok_in;
    logic [Q_W-1:0]     q;
    logic [YEAR_W-1:0]  rem;
    logic               rem_nz;
    logic [Q_W-1:0]     c100;
    logic [Q_W:0]       c100_p3;
    logic [Q_W-2:0]     c400;
    logic [YEAR_W:0]    y_p3;
    logic [LEAP_W-1:0]  c4;
    logic               leap;
    logic               day_ok;

    assign fin = dt_fields_t'(s_axis_tdata[g*DT_W +: DT_W]);

    // every range check that does not need the leap year
    assign ok_in = (fin.month >= MON_FIRST) && (fin.month <= MON_LAST) &&
                   (fin.day != '0) && (fin.year <= YEAR_MAX) &&
                   (fin.hour <= HOUR_MAX) && (fin.minute <= MIN_MAX) &&
                   (fin.second <= SEC_MAX);

    always_ff @(posedge clk) begin
      if (en1) begin
        fld1[g]  <= fin;
        ok1[g]   <= ok_in;
        prod1[g] <= PROD_W'(fin.year) * PROD_W'(RECIP_100);
      end
    end

    // century split: q = year / 100, rem = year % 100
    assign q       = prod1[g][PROD_W-1:RECIP_SHIFT];
    assign rem     = fld1[g].year - YEAR_W'(q) * YEAR_W'(CENTURY);
    assign rem_nz  = (rem != '0);
    // leap years before this year: ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign c100    = q + Q_W'(rem_nz);
    assign c100_p3 = {1'b0, c100} + (Q_W+1)'(3);
    assign c400    = c100_p3[Q_W:2];
    assign y_p3    = {1'b0, fld1[g].year} + (YEAR_W+1)'(3);
    assign c4      = y_p3[YEAR_W:2];
    // divisible by 4, and not a century unless divisible by 400
    assign leap    = (fld1[g].year[1:0] == 2'b00) && (rem_nz || (q[1:0] == 2'b00));
    assign day_ok  = (fld1[g].day <= month_len(fld1[g].month, leap));

    always_ff @(posedge clk) begin
      if (en2) begin
        y365_2[g] <= DAYNUM_W'(fld1[g].year) * DAYNUM_W'(DAYS_PER_YEAR);
        leaps2[g] <= c4 - LEAP_W'(c100) + LEAP_W'(c400);
        off2[g]   <= OFF_W'(days_before(fld1[g].month)) + OFF_W'(fld1[g].day)
                     - OFF_W'(1) + OFF_W'((fld1[g].month > MON_FEB) && leap);
        ok2[g]    <= ok1[g] && day_ok;
        tod2[g]   <= '{hour: fld1[g].hour, minute: fld1[g].minute,
                       second: fld1[g].second};
      end
    end

    // day number since the start of year 0
    always_ff @(posedge clk) begin
      if (en3) begin
        dnum3[g] <= y365_2[g] + DAYNUM_W'(leaps2[g]) + DAYNUM_W'(off2[g]);
        ok3[g]   <= ok2[g];
        tod3[g]  <= tod2[g];
      end
    end
  end

  // stage 4: order the two instants, later one first
  logic [DAYNUM_W-1:0] big_day4, small_day4;
  tod_t                big_tod4, small_tod4;
  logic                ok4;
  logic                a_later;

  assign a_later = {dnum3[0], tod3[0]} >= {dnum3[1], tod3[1]};

  always_ff @(posedge clk) begin
    if (en4) begin
      big_day4   <= a_later ? dnum3[0] : dnum3[1];
      small_day4 <= a_later ? dnum3[1] : dnum3[0];
      big_tod4   <= a_later ? tod3[0] : tod3[1];
      small_tod4 <= a_later ? tod3[1] : tod3[0];
      ok4        <= ok3[0] && ok3[1];
    end
  end

  // stage 5: mixed-radix subtract, borrows ripple seconds to days
  logic [SEC_W:0]      sec_d;
  logic [MIN_W:0]      min_d;
  logic [HOUR_W:0]     hour_d;
  logic [SEC_W-1:0]    sec_r;
  logic [MIN_W-1:0]    min_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [DAYNUM_W-1:0] day_r;
  logic [RES_W-1:0]    res;

  assign sec_d  = {1'b0, big_tod4.second} - {1'b0, small_tod4.second};
  assign min_d  = {1'b0, big_tod4.minute} - {1'b0, small_tod4.minute}
                  - (MIN_W+1)'(sec_d[SEC_W]);
  assign hour_d = {1'b0, big_tod4.hour} - {1'b0, small_tod4.hour}
                  - (HOUR_W+1)'(min_d[MIN_W]);
  // wrap back into range when a borrow was taken
  assign sec_r  = sec_d[SEC_W-1:0] + (sec_d[SEC_W] ? SECS_PER_MIN : '0);
  assign min_r  = min_d[MIN_W-1:0] + (min_d[MIN_W] ? MINS_PER_HOUR : '0);
  assign hour_r = hour_d[HOUR_W-1:0] + (hour_d[HOUR_W] ? HOURS_PER_DAY : '0);
  assign day_r  = big_day4 - small_day4 - DAYNUM_W'(hour_d[HOUR_W]);
  assign res    = {sec_r, min_r, hour_r, day_r[DAYS_W-1:0]};

  // output register; invalid pairs give all-zero fields
  always_ff @(posedge clk) begin
    if (en5) begin
      m_axis_tdata <= ok4 ? OUT_W'(res) : '0;
      m_axis_tuser <= ok4;
    end
  end

endmodule

// ----- hdl/dtdiff_checker.sv -----
// port-level checker for datetime_difference, bound to the top level
// depends on dtdiff_pkg and datetime_difference_defines.svh
`include "datetime_difference_defines.svh"

module dtdiff_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dtdiff_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);
  import dtdiff_pkg::*;

  // stalled result holds
  `DTD_ASSERT_NEXT(hold_a, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // invalid pair reports zero fields
  `DTD_ASSERT_IMPLY(zero_a, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid result with nonzero fields")

  // remainders stay in range
  `DTD_ASSERT_IMPLY(range_a, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[HRS_LSB +: HOUR_W] <= HOUR_MAX) && (m_axis_tdata[MINS_LSB +: MIN_W] <= MIN_MAX) && (m_axis_tdata[SECS_LSB +: SEC_W] <= SEC_MAX) && (m_axis_tdata[OUT_W-1:RES_W] == '0), "time remainder out of range")

  // empty output stage means the pipeline can take a transfer
  `DTD_ASSERT_IMPLY(ready_a, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")

  // nothing comes out right after reset
  `DTD_ASSERT_IMPLY(rst_a, $past(rst), !m_axis_tvalid, "result valid right after reset")

endmodule

bind datetime_difference dtdiff_checker u_dtdiff_checker (.*);
